[sv/hlsf_pkg.sv]
// shared types, constants and codes for the clipped span fill block
package hlsf_pkg;

  // default screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  // rows per page byte and the row bits that pick the bit inside it
  localparam int PAGE_ROWS = 8;
  localparam int ROW_BITS  = 3;

  // request codes
  localparam logic [1:0] REQ_DRAW   = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // colour codes
  localparam logic [1:0] MODE_BLACK  = 2'd0;
  localparam logic [1:0] MODE_WHITE  = 2'd1;
  localparam logic [1:0] MODE_GREY   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one request item
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] start_x;
    logic signed [15:0] row_y;
    logic [7:0]         span_width;
    logic [1:0]         colour_mode;
    logic [9:0]         byte_addr;
    logic [7:0]         write_byte;
  } req_t;

  // one response item
  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] pixels_drawn;
  } rsp_t;

endpackage

[sv/clipped_hline_span_fill_core.sv]
// top level: request sequencer, column walker and response register
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------
//   request | req_valid | req_stall | req (hlsf_pkg::req_t)
//   reply   | rsp_valid | rsp_stall | rsp (hlsf_pkg::rsp_t)
//
// a covering draw passes SPAN1 and SPAN2, reads one column per cycle while the one
// before is written back, ends with the final write-back and an empty walk step, then
// loads the reply; a dropped draw skips the walk, a zero-width one has only the empty
// step, a read passes ST_READ and a write or unused request goes straight to the load;
// the core is ready again once it loads the reply. after reset a clearing pass zeroes
// one byte per cycle with req_stall high; a waiting reply holds only the loading of the next reply.
module clipped_hline_span_fill_core #(
  parameter int SCREEN_WIDTH  = hlsf_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = hlsf_pkg::SCREEN_HEIGHT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  hlsf_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output hlsf_pkg::rsp_t  rsp
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + hlsf_pkg::PAGE_ROWS - 1) / hlsf_pkg::PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CXW         = $clog2(SCREEN_WIDTH + 1);
  localparam int CW          = ((AW > 10) ? AW : 10) + 1;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SPAN1 = 3'd2;
  localparam logic [2:0] ST_SPAN2 = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]     state;
  logic           accept;
  logic           in_range;
  logic           addr_ok;
  logic [AW-1:0]  clr_addr;

  // walker registers
  logic [AW-1:0]  rd_addr;
  logic [CXW-1:0] remaining;
  logic           par;
  logic [7:0]     mask;
  logic [1:0]     fill;
  logic           wr_pend;
  logic [AW-1:0]  wr_addr;
  logic           wr_set;
  logic           col_set;

  // result registers
  logic [7:0]     res_read;
  logic [7:0]     res_drawn;

  // memory ports
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  // span unit outputs
  logic           span_ok;
  logic [CXW-1:0] span_count;
  logic [AW-1:0]  span_base;
  logic [7:0]     span_mask;
  logic [1:0]     span_fill;
  logic           span_par;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign in_range  = CW'(req.byte_addr) < CW'(STORE_BYTES);

  // colour of the column being read this cycle
  always_comb begin
    case (fill)
      hlsf_pkg::MODE_WHITE: col_set = 1'b1;
      hlsf_pkg::MODE_GREY:  col_set = !par;
      default:              col_set = 1'b0;
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'd0;
    mem_raddr = AW'(req.byte_addr);
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && (req.req_type == hlsf_pkg::REQ_WRITE) && in_range) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(req.byte_addr);
          mem_wdata = req.write_byte;
        end
      end
      ST_WALK: begin
        mem_raddr = rd_addr;
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = wr_set ? (mem_rdata | mask) : (mem_rdata & ~mask);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // reply taken; the done state drives valid itself
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STORE_BYTES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_read  <= 8'd0;
            res_drawn <= 8'd0;
            addr_ok   <= in_range;
            case (req.req_type)
              hlsf_pkg::REQ_DRAW: state <= ST_SPAN1;
              hlsf_pkg::REQ_READ: state <= ST_READ;
              default:            state <= ST_DONE;
            endcase
          end
        end
        ST_SPAN1: begin
          state <= ST_SPAN2;
        end
        ST_SPAN2: begin
          rd_addr   <= span_base;
          remaining <= span_count;
          par       <= span_par;
          mask      <= span_mask;
          fill      <= span_fill;
          wr_pend   <= 1'b0;
          if (span_ok) begin
            res_drawn <= 8'(span_count);
            state     <= ST_WALK;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WALK: begin
          // read one column while the previous one is written back
          if (remaining != '0) begin
            rd_addr   <= rd_addr + 1'b1;
            remaining <= remaining - 1'b1;
            par       <= !par;
            wr_pend   <= 1'b1;
            wr_addr   <= rd_addr;
            wr_set    <= col_set;
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              state <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          res_read <= addr_ok ? mem_rdata : 8'd0;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // reply payload register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!rsp_valid || !rsp_stall)) begin
      rsp.read_byte    <= res_read;
      rsp.pixels_drawn <= res_drawn;
    end
  end

  // clip and address set-up
  hlsf_span #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .AW            (AW),
    .CXW           (CXW)
  ) u_span (
    .clk         (clk),
    .load        (accept),
    .start_x     (req.start_x),
    .row_y       (req.row_y),
    .span_width  (req.span_width),
    .colour_mode (req.colour_mode),
    .span_ok     (span_ok),
    .span_count  (span_count),
    .span_base   (span_base),
    .span_mask   (span_mask),
    .span_fill   (span_fill),
    .span_par    (span_par)
  );

  // framebuffer
  hlsf_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[sv/hlsf_store.sv]
// framebuffer byte memory, one write port and one registered read port
module hlsf_store #(
  parameter int DEPTH = hlsf_pkg::SCREEN_WIDTH * hlsf_pkg::SCREEN_HEIGHT / hlsf_pkg::PAGE_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/hlsf_span.sv]
// two-stage span clipper: row and span checks, clipping, then count, base address, row mask and dither phase
module hlsf_span #(
  parameter int SCREEN_WIDTH  = hlsf_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = hlsf_pkg::SCREEN_HEIGHT,
  parameter int AW            = 10,
  parameter int CXW           = $clog2(SCREEN_WIDTH + 1)
) (
  input  logic                clk,
  input  logic                load,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  row_y,
  input  logic [7:0]          span_width,
  input  logic [1:0]          colour_mode,
  output logic                span_ok,
  output logic [CXW-1:0]      span_count,
  output logic [AW-1:0]       span_base,
  output logic [7:0]          span_mask,
  output logic [1:0]          span_fill,
  output logic                span_par
);

  localparam int RW = $clog2(SCREEN_HEIGHT);

  // stage one signals
  logic signed [16:0] xs;
  logic signed [16:0] xe;
  logic               y_ok;
  logic               x_ok;
  logic               ok1;
  logic [CXW-1:0]     cs;
  logic [CXW-1:0]     ce;
  logic [RW-1:0]      row;
  logic [1:0]         fill1;

  // span ends at full width, no wrap
  always_comb begin
    xs   = {start_x[15], start_x};
    xe   = xs + $signed({9'b0, span_width});
    y_ok = !row_y[15] && (row_y[14:0] < 15'(SCREEN_HEIGHT));
    x_ok = (!xe[16] && (xe[15:0] != 16'd0))
        && (xs[16] || (xs[15:0] < 16'(SCREEN_WIDTH)));
  end

  // stage one: checks and clipping
  always_ff @(posedge clk) begin
    if (load) begin
      ok1   <= y_ok && x_ok && (colour_mode != hlsf_pkg::MODE_UNUSED);
      cs    <= xs[16] ? '0 : CXW'(xs[15:0]);
      ce    <= (!xe[16] && (xe[15:0] > 16'(SCREEN_WIDTH))) ? CXW'(SCREEN_WIDTH)
                                                            : CXW'(xe[15:0]);
      row   <= RW'(row_y[15:0]);
      fill1 <= colour_mode;
    end
  end

  // stage two: count, page base address, row mask, dither phase
  always_ff @(posedge clk) begin
    span_ok    <= ok1;
    span_count <= ce - cs;
    span_base  <= AW'(AW'(row >> hlsf_pkg::ROW_BITS) * AW'(SCREEN_WIDTH)) + AW'(cs);
    span_mask  <= 8'(1) << row[hlsf_pkg::ROW_BITS-1:0];
    span_fill  <= fill1;
    span_par   <= cs[0] ^ row[0];
  end

endmodule
